// ===== sv/ndrm_pkg.sv =====
// Package for the nearest delta-R matcher: widths, constants and shared types.
// Used by ndrm_cell, ndrm_dist and nearest_delta_r_matcher_top; depends on nothing.
package ndrm_pkg;

  // Capacity of the reconstructed object store.
  localparam int MaxReco = 64;
  localparam int IdxW    = (MaxReco > 1) ? $clog2(MaxReco) : 1;
  localparam int CntW    = $clog2(MaxReco + 1);

  // Field widths.
  localparam int EtaW   = 14;
  localparam int PhiW   = 13;
  localparam int GapW   = 12;
  localparam int DrW    = 29;
  localparam int NumW   = 8;
  localparam int BiW    = 6;
  localparam int OpW    = 2;
  localparam int CfgIdxW = 2;

  // Opcodes.
  localparam logic [OpW-1:0] OP_CLEAR = 2'd0;
  localparam logic [OpW-1:0] OP_LOAD  = 2'd1;
  localparam logic [OpW-1:0] OP_MATCH = 2'd2;
  localparam logic [OpW-1:0] OP_END   = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_MAX_DR_SQ   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_MATCHES = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_MATCHES = 2'd2;

  localparam logic [DrW-1:0] MAX_DR_SQ_RST = 29'd262144;

  // Pi and two pi in units of 1/1024 rad.
  localparam logic [PhiW-1:0] PHI_PI     = 13'd3217;
  localparam logic [PhiW-1:0] PHI_TWO_PI = 13'd6434;

  // Common control to every cell of the ring.
  typedef struct packed {
    logic            shift;
    logic [EtaW-1:0] wr_eta;
    logic [PhiW-1:0] wr_phi;
  } cell_ctl_t;

  // One stored object presented to the distance unit.
  typedef struct packed {
    logic            go;
    logic            vld;
    logic            last;
    logic [IdxW-1:0] idx;
    logic [EtaW-1:0] eta;
    logic [PhiW-1:0] phi;
  } dist_feed_t;

  // Outcome of one scan.
  typedef struct packed {
    logic            done;
    logic            hit;
    logic [IdxW-1:0] idx;
    logic [DrW-1:0]  dr;
  } dist_res_t;

endpackage

// ===== sv/ndrm_cell.sv =====
// One cell of the object ring: holds one stored object and passes it to its neighbor.
// Depends on ndrm_pkg.
module ndrm_cell (
  input  logic                      clk_i,
  input  ndrm_pkg::cell_ctl_t       ctl_i,
  input  logic                      wr_en_i,
  input  logic [ndrm_pkg::EtaW-1:0] nb_eta_i,
  input  logic [ndrm_pkg::PhiW-1:0] nb_phi_i,
  output logic [ndrm_pkg::EtaW-1:0] eta_o,
  output logic [ndrm_pkg::PhiW-1:0] phi_o
);

  logic [ndrm_pkg::EtaW-1:0] eta_q;
  logic [ndrm_pkg::PhiW-1:0] phi_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      eta_q <= ctl_i.wr_eta;
      phi_q <= ctl_i.wr_phi;
    end else if (ctl_i.shift) begin
      eta_q <= nb_eta_i;
      phi_q <= nb_phi_i;
    end
  end

  assign eta_o = eta_q;
  assign phi_o = phi_q;

endmodule

// ===== sv/ndrm_dist.sv =====
// Pipelined squared-distance unit with running minimum for the tile scan.
// Depends on ndrm_pkg.
module ndrm_dist (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ndrm_pkg::DrW-1:0]  max_dr_sq_i,
  input  logic [ndrm_pkg::EtaW-1:0] tile_eta_i,
  input  logic [ndrm_pkg::PhiW-1:0] tile_phi_i,
  input  ndrm_pkg::dist_feed_t      feed_i,
  output ndrm_pkg::dist_res_t       res_o
);

  // Stage A: absolute differences, with the phi gap wrapped at pi.
  logic signed [ndrm_pkg::EtaW:0] de;
  logic [ndrm_pkg::EtaW:0]        de_abs;
  logic [ndrm_pkg::PhiW-1:0]      dphi;
  logic [ndrm_pkg::PhiW-1:0]      dwrap;
  logic [ndrm_pkg::GapW-1:0]      gap;

  always_comb begin
    de     = $signed({tile_eta_i[ndrm_pkg::EtaW-1], tile_eta_i})
           - $signed({feed_i.eta[ndrm_pkg::EtaW-1], feed_i.eta});
    de_abs = de[ndrm_pkg::EtaW] ? (~de + 1'b1) : de;
    dphi   = (tile_phi_i >= feed_i.phi) ? (tile_phi_i - feed_i.phi)
                                        : (feed_i.phi - tile_phi_i);
    dwrap  = (dphi <= ndrm_pkg::PHI_TWO_PI) ? (ndrm_pkg::PHI_TWO_PI - dphi)
                                            : (dphi - ndrm_pkg::PHI_TWO_PI);
    gap    = (dphi > ndrm_pkg::PHI_PI) ? dwrap[ndrm_pkg::GapW-1:0]
                                       : dphi[ndrm_pkg::GapW-1:0];
  end

  logic                        a_go_q, a_vld_q, a_last_q;
  logic [ndrm_pkg::IdxW-1:0]   a_idx_q;
  logic [ndrm_pkg::EtaW-1:0]   a_ae_q;
  logic [ndrm_pkg::GapW-1:0]   a_gap_q;

  // Stage B: squares.
  logic                          b_go_q, b_vld_q, b_last_q;
  logic [ndrm_pkg::IdxW-1:0]     b_idx_q;
  logic [2*ndrm_pkg::EtaW-1:0]   b_sqe_q;
  logic [2*ndrm_pkg::GapW-1:0]   b_sqp_q;

  // Stage C: sum and running minimum.
  logic [ndrm_pkg::DrW-1:0]  dr;
  logic                      better;
  logic                      hit_q, done_q;
  logic [ndrm_pkg::IdxW-1:0] best_idx_q;
  logic [ndrm_pkg::DrW-1:0]  best_q;

  assign dr     = ndrm_pkg::DrW'(b_sqe_q) + ndrm_pkg::DrW'(b_sqp_q);
  assign better = b_go_q && b_vld_q && (dr < best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_go_q <= 1'b0;
      b_go_q <= 1'b0;
      done_q <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      a_go_q <= feed_i.go;
      b_go_q <= a_go_q;
      done_q <= b_go_q && b_last_q;
      if (start_i) begin
        hit_q <= 1'b0;
      end else if (better) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_vld_q  <= feed_i.vld;
    a_last_q <= feed_i.last;
    a_idx_q  <= feed_i.idx;
    a_ae_q   <= de_abs[ndrm_pkg::EtaW-1:0];
    a_gap_q  <= gap;
    b_vld_q  <= a_vld_q;
    b_last_q <= a_last_q;
    b_idx_q  <= a_idx_q;
    b_sqe_q  <= a_ae_q * a_ae_q;
    b_sqp_q  <= a_gap_q * a_gap_q;
    if (start_i) begin
      best_q     <= max_dr_sq_i;
      best_idx_q <= '0;
    end else if (better) begin
      best_q     <= dr;
      best_idx_q <= b_idx_q;
    end
  end

  assign res_o.done = done_q;
  assign res_o.hit  = hit_q;
  assign res_o.idx  = best_idx_q;
  assign res_o.dr   = best_q;

endmodule

// ===== sv/nearest_delta_r_matcher_top.sv =====
// Top level of the nearest delta-R matcher: object ring, distance unit and control.
// Depends on ndrm_pkg, ndrm_cell and ndrm_dist.
//
// Usage: items enter on the input channel (in_valid_i, in_stall_o) and carry an
// opcode with an eta and a phi. A clear item empties the object store and zeroes
// the event match count; a load item appends one object to the store and is
// dropped once the store holds MaxReco objects. Neither gives a result. A match item
// rotates the ring of object cells once around, so that every cell passes the
// distance unit in turn, whatever the fill level; the nearest distance is then
// written to the result register. An end-event item gives its decision result
// through the same register. Only one item is worked on at a time: in_stall_o
// is high from acceptance until the result has been written. Results leave through
// one output register (out_valid_o, out_stall_i). While the receiver stalls, the
// register holds its item; a finished result waits inside the block until the
// register frees, and no new item is taken meanwhile.
// Reset empties the store, zeroes the match count and loads the register reset
// values; the store contents themselves are not cleared, since only entries below
// the fill count are ever used. The user must write configuration through
// cfg_we_i only while the block is idle; the block itself does not enforce this.
module nearest_delta_r_matcher_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic [ndrm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ndrm_pkg::DrW-1:0]     cfg_data_i,
  // Input channel.
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ndrm_pkg::OpW-1:0]     opcode_i,
  input  logic signed [ndrm_pkg::EtaW-1:0] eta_i,
  input  logic [ndrm_pkg::PhiW-1:0]    phi_i,
  // Output channel.
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         kind_o,
  output logic                         matched_o,
  output logic [ndrm_pkg::BiW-1:0]     best_index_o,
  output logic [ndrm_pkg::DrW-1:0]     best_dr_sq_o,
  output logic [ndrm_pkg::NumW-1:0]    match_count_o,
  output logic                         event_pass_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam logic [ndrm_pkg::CntW-1:0] LastPos = ndrm_pkg::CntW'(ndrm_pkg::MaxReco - 1);
  localparam logic [ndrm_pkg::CntW-1:0] Full    = ndrm_pkg::CntW'(ndrm_pkg::MaxReco);

  logic [1:0] state_q, state_d;

  // Configuration registers.
  logic [ndrm_pkg::DrW-1:0]  max_dr_sq_q;
  logic [ndrm_pkg::NumW-1:0] min_matches_q, max_matches_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dr_sq_q   <= ndrm_pkg::MAX_DR_SQ_RST;
      min_matches_q <= '0;
      max_matches_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ndrm_pkg::CFG_MAX_DR_SQ:   max_dr_sq_q   <= cfg_data_i;
        ndrm_pkg::CFG_MIN_MATCHES: min_matches_q <= cfg_data_i[ndrm_pkg::NumW-1:0];
        ndrm_pkg::CFG_MAX_MATCHES: max_matches_q <= cfg_data_i[ndrm_pkg::NumW-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake.
  logic in_acc;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  logic op_clear, op_load, op_match, op_end;
  assign op_clear = in_acc && (opcode_i == ndrm_pkg::OP_CLEAR);
  assign op_load  = in_acc && (opcode_i == ndrm_pkg::OP_LOAD);
  assign op_match = in_acc && (opcode_i == ndrm_pkg::OP_MATCH);
  assign op_end   = in_acc && (opcode_i == ndrm_pkg::OP_END);

  // Event state.
  logic [ndrm_pkg::CntW-1:0] reco_count_q;
  logic [ndrm_pkg::NumW-1:0] match_total_q, match_total_d;
  logic                      store_full;
  assign store_full = (reco_count_q == Full);

  // Tile held for the scan, and the kind of result pending.
  logic [ndrm_pkg::EtaW-1:0] tile_eta_q;
  logic [ndrm_pkg::PhiW-1:0] tile_phi_q;
  logic                      kind_q;

  always_ff @(posedge clk_i) begin
    if (op_match) begin
      tile_eta_q <= eta_i;
      tile_phi_q <= phi_i;
    end
  end

  // Scan sequencer: the ring shifts once per cycle until it has turned once around.
  logic                      issue_q;
  logic [ndrm_pkg::CntW-1:0] scan_cnt_q;
  logic                      scan_last;
  assign scan_last = (scan_cnt_q == LastPos);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q    <= 1'b0;
      scan_cnt_q <= '0;
    end else if (op_match) begin
      issue_q    <= 1'b1;
      scan_cnt_q <= '0;
    end else if (issue_q) begin
      issue_q    <= !scan_last;
      scan_cnt_q <= scan_last ? scan_cnt_q : scan_cnt_q + 1'b1;
    end
  end

  // Object ring. Cell k takes the contents of cell k+1; cell 0 wraps to the end.
  ndrm_pkg::cell_ctl_t       cell_ctl;
  logic [ndrm_pkg::EtaW-1:0] ring_eta [ndrm_pkg::MaxReco];
  logic [ndrm_pkg::PhiW-1:0] ring_phi [ndrm_pkg::MaxReco];

  assign cell_ctl.shift  = issue_q;
  assign cell_ctl.wr_eta = eta_i;
  assign cell_ctl.wr_phi = phi_i;

  for (genvar k = 0; k < ndrm_pkg::MaxReco; k++) begin : g_cell
    logic wr_en;
    assign wr_en = op_load && !store_full &&
                   (reco_count_q[ndrm_pkg::IdxW-1:0] == ndrm_pkg::IdxW'(k));
    ndrm_cell u_cell (
      .clk_i    (clk_i),
      .ctl_i    (cell_ctl),
      .wr_en_i  (wr_en),
      .nb_eta_i (ring_eta[(k + 1) % ndrm_pkg::MaxReco]),
      .nb_phi_i (ring_phi[(k + 1) % ndrm_pkg::MaxReco]),
      .eta_o    (ring_eta[k]),
      .phi_o    (ring_phi[k])
    );
  end

  // Distance unit fed from the head of the ring.
  ndrm_pkg::dist_feed_t feed;
  ndrm_pkg::dist_res_t  res;

  assign feed.go   = issue_q;
  assign feed.vld  = scan_cnt_q < reco_count_q;
  assign feed.last = scan_last;
  assign feed.idx  = scan_cnt_q[ndrm_pkg::IdxW-1:0];
  assign feed.eta  = ring_eta[0];
  assign feed.phi  = ring_phi[0];

  ndrm_dist u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (op_match),
    .max_dr_sq_i (max_dr_sq_q),
    .tile_eta_i  (tile_eta_q),
    .tile_phi_i  (tile_phi_q),
    .feed_i      (feed),
    .res_o       (res)
  );

  // Output register.
  logic                      out_valid_q;
  logic                      out_free;
  logic                      emit;
  logic                      kind_out_q, matched_q, pass_q;
  logic [ndrm_pkg::BiW-1:0]  best_index_q;
  logic [ndrm_pkg::DrW-1:0]  best_dr_q;
  logic [ndrm_pkg::NumW-1:0] count_out_q;
  logic                      pass;

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = (state_q == ST_EMIT) && out_free;

  assign pass = ((min_matches_q == '0) || (match_total_q >= min_matches_q)) &&
                ((max_matches_q == '0) || (match_total_q <= max_matches_q));

  // A hit counts once the tile result is written, saturating at the top.
  always_comb begin
    match_total_d = match_total_q;
    if (!kind_q && res.hit && (match_total_q != '1)) begin
      match_total_d = match_total_q + 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (op_match) begin
          state_d = ST_SCAN;
        end else if (op_end) begin
          state_d = ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (res.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      reco_count_q  <= '0;
      match_total_q <= '0;
      kind_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (op_clear) begin
        reco_count_q  <= '0;
        match_total_q <= '0;
      end else begin
        if (op_load && !store_full) begin
          reco_count_q <= reco_count_q + 1'b1;
        end
        if (emit) begin
          match_total_q <= match_total_d;
        end
      end
      if (op_match) begin
        kind_q <= 1'b0;
      end else if (op_end) begin
        kind_q <= 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_out_q   <= kind_q;
      matched_q    <= !kind_q && res.hit;
      best_index_q <= (!kind_q && res.hit) ? ndrm_pkg::BiW'(res.idx) : '0;
      best_dr_q    <= (!kind_q && res.hit) ? res.dr : '0;
      count_out_q  <= match_total_d;
      pass_q       <= kind_q && pass;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_out_q;
  assign matched_o     = matched_q;
  assign best_index_o  = best_index_q;
  assign best_dr_sq_o  = best_dr_q;
  assign match_count_o = count_out_q;
  assign event_pass_o  = pass_q;

  // The fill count never passes the store capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reco_count_q <= Full)
    else $error("object count above capacity");

  // A scan finishes only while the block is scanning.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.done |-> (state_q == ST_SCAN))
    else $error("scan finished outside a scan");

  // A new result is written only from the emit state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result appeared without an emit");

  // The match count falls only through a clear item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (match_total_q < $past(match_total_q)) |-> $past(op_clear))
    else $error("match count fell without a clear");

  // The ring shifts only while the block is scanning.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_q |-> (state_q == ST_SCAN))
    else $error("ring shift outside a scan");

endmodule
